// ===== design/astg_pkg.sv =====
// Package for the sawtooth tone generator with ADSR envelope.
// Types, field widths, register indexes and segment codes.
// Used by astg_mul, astg_div and adsr_sawtooth_tone_generator.
`timescale 1ns / 1ps
`default_nettype none

package astg_pkg;

   // Field widths
   localparam int LEVEL_W  = 15;
   localparam int TIME_W   = 16;
   localparam int DUR_W    = 20;
   localparam int PERIOD_W = 12;
   localparam int MASK_W   = 2;
   localparam int SEG_W    = 3;
   localparam int SMP_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Sustain scale: 1 << LENGTH_SHIFT is the nominal length
   localparam int LENGTH_SHIFT = 8;
   // Samples saturate to this many signed bits before going onto the 16-bit port
   localparam int SAMPLE_BITS  = 16;
   localparam int SAT_HI = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SAT_LO = -SAT_HI - 1;

   // Serial multiplier: 20-bit multiplicand, 16-bit multiplier, one bit per cycle
   localparam int MUL_A_W   = 20;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // Serial divider: quotient known to fit 15 bits, one bit per cycle
   localparam int DIV_D_W   = 20;
   localparam int DIV_Q_W   = 15;
   localparam int DIV_N_W   = DIV_D_W + DIV_Q_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   // Command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // Envelope segments
   localparam logic [SEG_W-1:0] SEG_ATTACK  = 3'd0;
   localparam logic [SEG_W-1:0] SEG_DECAY   = 3'd1;
   localparam logic [SEG_W-1:0] SEG_SUSTAIN = 3'd2;
   localparam logic [SEG_W-1:0] SEG_RELEASE = 3'd3;
   localparam logic [SEG_W-1:0] SEG_IDLE    = 3'd4;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK_LEVEL,
      CSR_SUSTAIN_LEVEL,
      CSR_ATTACK_TIME,
      CSR_DECAY_TIME,
      CSR_SUSTAIN_TIME,
      CSR_RELEASE_TIME
   } astg_csr_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_READY,
      ST_AMP_MUL,
      ST_AMP_DIV,
      ST_WAVE_MUL,
      ST_WAVE_DIV,
      ST_ENTER,
      ST_SUS_MUL,
      ST_EMIT
   } astg_state_type;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } astg_unit_stat_type;

endpackage

`default_nettype wire

// ===== design/astg_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on astg_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module astg_mul (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [astg_pkg::MUL_A_W-1:0]     mcand,
   input  wire  [astg_pkg::MUL_B_W-1:0]     mplier,
   output logic [astg_pkg::MUL_P_W-1:0]     product,
   output astg_pkg::astg_unit_stat_type     stat
);
   import astg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_P_W-1:0]   prod_ff, prod_in;
   logic [MUL_A_W:0]     part_sum;

   // Add the multiplicand to the upper half when the low bit is set, then shift right
   always_comb begin
      part_sum = {1'b0, prod_ff[MUL_P_W-1:MUL_B_W]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = MUL_CNT_W'(MUL_B_W - 1);
         mcand_in = mcand;
         prod_in  = {{MUL_A_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         prod_in = {part_sum, prod_ff[MUL_B_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial product
   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign product   = prod_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ===== design/astg_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits DIV_Q_W bits. Depends on astg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module astg_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [astg_pkg::DIV_N_W-1:0]     dividend,
   input  wire  [astg_pkg::DIV_D_W-1:0]     divisor,
   output logic [astg_pkg::DIV_Q_W-1:0]     quotient,
   output astg_pkg::astg_unit_stat_type     stat
);
   import astg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     trial_sub;
   logic                 fits;

   // Shift in the next dividend bit, subtract if the divisor fits
   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_Q_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_Q_W - 1);
         dvs_in  = divisor;
         rem_in  = dividend[DIV_N_W-1:DIV_Q_W];
         quo_in  = dividend[DIV_Q_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Divisor, partial remainder and quotient shift register
   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ===== design/adsr_sawtooth_tone_generator.sv =====
// Sawtooth tone generator with linear ADSR envelope: sequencer, state, registers.
// Depends on astg_pkg, astg_mul and astg_div.
//
// req_*  carries commands. A start (req_command = 1) loads a note and gives no
//        response; a tick (req_command = 0) gives one rsp_* transfer.
// rsp_*  carries one stereo sample pair per tick, with playing and note_end.
// csr_*  writes the six envelope registers by index; csr_ready is always high.
//        The user must write registers only while no command is in flight; the block does not enforce it.
// A tick in a note runs a serial multiply and divide for the envelope, then the
// same for the waveform; the sequencer launches each unit when the previous one
// is done. At a segment boundary it also steps through each segment entered and,
// for sustain, runs the length multiply. An idle tick goes straight to output.
// After a start the sequencer enters the first non-empty segment before it takes
// the next command.
// One command is processed at a time; the result sits in an output register, so
// the next command is accepted while it waits for rsp_ready. A stalled receiver
// only holds the block once a second result is ready.
// Reset: synchronous, active high; registers return to their defaults and the
// envelope goes idle.
`timescale 1ns / 1ps
`default_nettype none

module adsr_sawtooth_tone_generator (
   input  wire               clock,
   input  wire               reset,
   // command channel
   input  wire               req_valid,
   output logic              req_ready,
   input  wire               req_command,
   input  wire  [11:0]       req_wavelength,
   input  wire  [1:0]        req_channel_mask,
   input  wire  [11:0]       req_note_length,
   // sample channel
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic              rsp_playing,
   output logic              rsp_note_end,
   // register write channel
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [2:0]        csr_index,
   input  wire  [15:0]       csr_wdata
);
   import astg_pkg::*;

   astg_state_type state_ff, state_in;

   // Configuration registers
   logic [LEVEL_W-1:0] attack_level_ff, sustain_level_ff;
   logic [TIME_W-1:0]  attack_time_ff, decay_time_ff, sustain_time_ff, release_time_ff;

   // Note and envelope state
   logic [SEG_W-1:0]    segment_ff, segment_in;
   logic [DUR_W-1:0]    position_ff, position_in;
   logic [DUR_W-1:0]    duration_ff, duration_in;
   logic [PERIOD_W-1:0] phase_ff, phase_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [MASK_W-1:0]   channels_ff, channels_in;
   logic [11:0]         length_scale_ff, length_scale_in;
   logic [LEVEL_W-1:0]  ramp_start_ff, ramp_start_in;
   logic                tick_mode_ff, tick_mode_in;
   logic                play_ff, play_in;
   logic                last_ff, last_in;
   logic [SMP_W-1:0]    smp_ff, smp_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SMP_W-1:0] rsp_right_ff, rsp_right_in;
   logic                rsp_playing_ff, rsp_playing_in;
   logic                rsp_note_end_ff, rsp_note_end_in;

   // Arithmetic units
   logic               mul_start;
   logic [MUL_A_W-1:0] mul_mcand;
   logic [MUL_B_W-1:0] mul_mplier;
   logic [MUL_P_W-1:0] mul_product;
   astg_unit_stat_type mul_stat;
   logic               div_start;
   logic [DIV_N_W-1:0] div_dividend;
   logic [DIV_D_W-1:0] div_divisor;
   logic [DIV_Q_W-1:0] div_quotient;
   astg_unit_stat_type div_stat;

   // Derived values
   logic [LEVEL_W-1:0]  seg_target;
   logic [TIME_W-1:0]   fixed_len;
   logic                diff_neg;
   logic [LEVEL_W-1:0]  diff_mag;
   logic [PERIOD_W:0]   two_phase;
   logic                wave_neg;
   logic [PERIOD_W:0]   wave_diff;
   logic [LEVEL_W:0]    amp_wide;
   logic signed [SMP_W-1:0] wave_val;
   logic signed [31:0]  wave_ext;
   logic signed [31:0]  wave_sat;
   logic [MUL_P_W-1:0]  sus_full;
   logic [DUR_W-1:0]    sus_len;
   logic [DUR_W:0]      position_next;
   logic [PERIOD_W-1:0] phase_next;
   logic                note_idle;
   logic                req_xfer;
   logic                rsp_free;

   astg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (mul_product),
      .stat    (mul_stat)
   );

   astg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   assign req_ready = (state_ff == ST_READY);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Segment target and fixed segment lengths
   always_comb begin
      case (segment_ff)
         SEG_ATTACK:              seg_target = attack_level_ff;
         SEG_DECAY, SEG_SUSTAIN:  seg_target = sustain_level_ff;
         default:                 seg_target = '0;
      endcase
      case (segment_ff)
         SEG_ATTACK:  fixed_len = attack_time_ff;
         SEG_DECAY:   fixed_len = decay_time_ff;
         SEG_RELEASE: fixed_len = release_time_ff;
         default:     fixed_len = '0;
      endcase
   end

   // Sign and magnitude of the envelope slope and of the sawtooth offset
   always_comb begin
      diff_neg  = seg_target < ramp_start_ff;
      diff_mag  = diff_neg ? ramp_start_ff - seg_target : seg_target - ramp_start_ff;
      two_phase = {phase_ff, 1'b0};
      wave_neg  = two_phase < {1'b0, period_ff};
      wave_diff = wave_neg ? {1'b0, period_ff} - two_phase : two_phase - {1'b0, period_ff};
   end

   // Envelope amplitude and sample from the divider results, saturated
   always_comb begin
      amp_wide = diff_neg ? {1'b0, ramp_start_ff} - {1'b0, div_quotient}
                          : {1'b0, ramp_start_ff} + {1'b0, div_quotient};
      wave_val = wave_neg ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
      wave_ext = 32'(wave_val);
      if (wave_ext > SAT_HI) begin
         wave_sat = SAT_HI;
      end else if (wave_ext < SAT_LO) begin
         wave_sat = SAT_LO;
      end else begin
         wave_sat = wave_ext;
      end
   end

   // Scaled sustain length, saturated to the duration width
   always_comb begin
      sus_full = mul_product >> LENGTH_SHIFT;
      sus_len  = (|sus_full[MUL_P_W-1:DUR_W]) ? '1 : sus_full[DUR_W-1:0];
   end

   // Counters for the tick update
   always_comb begin
      note_idle     = (segment_ff >= SEG_IDLE) || (duration_ff == '0);
      position_next = {1'b0, position_ff} + 1'b1;
      phase_next    = (phase_ff + 1'b1 >= period_ff) ? '0 : phase_ff + 1'b1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               if (req_command == CMD_START) begin
                  state_in = ST_ENTER;
               end else if (note_idle) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_AMP_MUL;
               end
            end
         end
         ST_AMP_MUL: begin
            if (mul_stat.done) state_in = ST_AMP_DIV;
         end
         ST_AMP_DIV: begin
            if (div_stat.done) state_in = ST_WAVE_MUL;
         end
         ST_WAVE_MUL: begin
            if (mul_stat.done) state_in = ST_WAVE_DIV;
         end
         ST_WAVE_DIV: begin
            if (div_stat.done) begin
               state_in = (position_next >= {1'b0, duration_ff}) ? ST_ENTER : ST_EMIT;
            end
         end
         ST_ENTER: begin
            if (segment_ff >= SEG_IDLE) begin
               state_in = tick_mode_ff ? ST_EMIT : ST_READY;
            end else if (segment_ff == SEG_SUSTAIN) begin
               state_in = ST_SUS_MUL;
            end else if (fixed_len != '0) begin
               state_in = tick_mode_ff ? ST_EMIT : ST_READY;
            end
         end
         ST_SUS_MUL: begin
            if (mul_stat.done) begin
               if (sus_len != '0) begin
                  state_in = tick_mode_ff ? ST_EMIT : ST_READY;
               end else begin
                  state_in = ST_ENTER;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) state_in = ST_READY;
         end
         default: state_in = ST_READY;
      endcase
   end

   // Unit launches and state updates
   always_comb begin
      mul_start       = 1'b0;
      mul_mcand       = position_ff;
      mul_mplier      = {1'b0, diff_mag};
      div_start       = 1'b0;
      div_dividend    = mul_product[DIV_N_W-1:0];
      div_divisor     = duration_ff;
      segment_in      = segment_ff;
      position_in     = position_ff;
      duration_in     = duration_ff;
      phase_in        = phase_ff;
      period_in       = period_ff;
      channels_in     = channels_ff;
      length_scale_in = length_scale_ff;
      ramp_start_in   = ramp_start_ff;
      tick_mode_in    = tick_mode_ff;
      play_in         = play_ff;
      last_in         = last_ff;
      smp_in          = smp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_playing_in  = rsp_playing_ff;
      rsp_note_end_in = rsp_note_end_ff;
      case (state_ff)
         // Take a command: load a note, answer an idle tick, or start the slope product
         ST_READY: begin
            if (req_xfer) begin
               if (req_command == CMD_START) begin
                  period_in       = (req_wavelength == '0) ? PERIOD_W'(1) : req_wavelength;
                  channels_in     = req_channel_mask;
                  length_scale_in = req_note_length;
                  phase_in        = '0;
                  ramp_start_in   = '0;
                  segment_in      = SEG_ATTACK;
                  tick_mode_in    = 1'b0;
               end else if (note_idle) begin
                  smp_in  = '0;
                  play_in = 1'b0;
                  last_in = 1'b0;
               end else begin
                  mul_start = 1'b1;
               end
            end
         end
         // (target - start) * position / duration
         ST_AMP_MUL: begin
            div_start = mul_stat.done;
         end
         // Amplitude ready: multiply by the sawtooth offset
         ST_AMP_DIV: begin
            mul_mcand  = {{(MUL_A_W-LEVEL_W){1'b0}}, amp_wide[LEVEL_W-1:0]};
            mul_mplier = {{(MUL_B_W-PERIOD_W){1'b0}}, wave_diff[PERIOD_W-1:0]};
            mul_start  = div_stat.done;
         end
         ST_WAVE_MUL: begin
            div_divisor = {{(DIV_D_W-PERIOD_W){1'b0}}, period_ff};
            div_start   = mul_stat.done;
         end
         // Sample ready: advance phase and envelope position, or step to the next segment at its end
         ST_WAVE_DIV: begin
            if (div_stat.done) begin
               smp_in   = wave_sat[SMP_W-1:0];
               play_in  = 1'b1;
               last_in  = 1'b0;
               phase_in = phase_next;
               if (position_next >= {1'b0, duration_ff}) begin
                  ramp_start_in = seg_target;
                  segment_in    = segment_ff + 1'b1;
                  tick_mode_in  = 1'b1;
               end else begin
                  position_in = position_next[DUR_W-1:0];
               end
            end
         end
         // Enter the current segment, skipping empty ones
         ST_ENTER: begin
            mul_mcand  = {{(MUL_A_W-12){1'b0}}, length_scale_ff};
            mul_mplier = sustain_time_ff;
            if (segment_ff >= SEG_IDLE) begin
               position_in = '0;
               duration_in = '0;
               last_in     = tick_mode_ff;
            end else if (segment_ff == SEG_SUSTAIN) begin
               mul_start = 1'b1;
            end else if (fixed_len != '0) begin
               duration_in = {{(DUR_W-TIME_W){1'b0}}, fixed_len};
               position_in = '0;
            end else begin
               ramp_start_in = seg_target;
               segment_in    = segment_ff + 1'b1;
            end
         end
         ST_SUS_MUL: begin
            if (mul_stat.done) begin
               if (sus_len != '0) begin
                  duration_in = sus_len;
                  position_in = '0;
               end else begin
                  ramp_start_in = seg_target;
                  segment_in    = segment_ff + 1'b1;
               end
            end
         end
         // Hand the result to the output register once it is free
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_left_in     = (channels_ff[0] && play_ff) ? $signed(smp_ff) : '0;
               rsp_right_in    = (channels_ff[1] && play_ff) ? $signed(smp_ff) : '0;
               rsp_playing_in  = play_ff;
               rsp_note_end_in = last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and note state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_READY;
         attack_level_ff  <= LEVEL_W'(32767);
         sustain_level_ff <= LEVEL_W'(16384);
         attack_time_ff   <= TIME_W'(2400);
         decay_time_ff    <= TIME_W'(2400);
         sustain_time_ff  <= TIME_W'(9600);
         release_time_ff  <= TIME_W'(960);
         segment_ff       <= SEG_IDLE;
         position_ff      <= '0;
         duration_ff      <= '0;
         phase_ff         <= '0;
         period_ff        <= PERIOD_W'(1);
         channels_ff      <= '0;
         length_scale_ff  <= 12'd256;
         ramp_start_ff    <= '0;
         tick_mode_ff     <= 1'b0;
         play_ff          <= 1'b0;
         last_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         segment_ff      <= segment_in;
         position_ff     <= position_in;
         duration_ff     <= duration_in;
         phase_ff        <= phase_in;
         period_ff       <= period_in;
         channels_ff     <= channels_in;
         length_scale_ff <= length_scale_in;
         ramp_start_ff   <= ramp_start_in;
         tick_mode_ff    <= tick_mode_in;
         play_ff         <= play_in;
         last_ff         <= last_in;
         rsp_valid_ff    <= rsp_valid_in;
         // Register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ATTACK_LEVEL:  attack_level_ff  <= csr_wdata[LEVEL_W-1:0];
               CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata[LEVEL_W-1:0];
               CSR_ATTACK_TIME:   attack_time_ff   <= csr_wdata;
               CSR_DECAY_TIME:    decay_time_ff    <= csr_wdata;
               CSR_SUSTAIN_TIME:  sustain_time_ff  <= csr_wdata;
               CSR_RELEASE_TIME:  release_time_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Sample and output payload
   always_ff @(posedge clock) begin
      smp_ff          <= smp_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_playing_ff  <= rsp_playing_in;
      rsp_note_end_ff <= rsp_note_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;
   assign rsp_playing      = rsp_playing_ff;
   assign rsp_note_end     = rsp_note_end_ff;

`ifndef SYNTHESIS
   // The two serial units are used strictly in turn
   assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   // No command is taken while arithmetic is in flight
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!mul_stat.busy && !div_stat.busy))
      else $error("command taken while a unit is busy");

   // Between commands, a live segment has its position inside its duration
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READY && segment_ff < SEG_IDLE) |-> (position_ff < duration_ff))
      else $error("envelope position outside segment");

   // The end of a note is only flagged on a note sample
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_note_end) |-> rsp_playing)
      else $error("note end flagged on an idle sample");
`endif

endmodule

`default_nettype wire
